// ----- rtl/core/sisort_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sisort_pkg
// Shared types and constants of the stable distance-key sorter.
// ============================================================================
package sisort_pkg;

    localparam int VALUE_W      = 32;
    localparam int KEY_W        = 3;
    localparam int ENTRY_W      = VALUE_W + KEY_W;
    localparam int OUT_TDATA_W  = ((ENTRY_W + 7) / 8) * 8;
    localparam int CAPACITY_DEF = 64;

    localparam int SUM_W        = 10;
    localparam int PROD_W       = 18;
    localparam int QUOT_W       = 7;
    localparam int REM_W        = 4;
    localparam int DIV10_MUL    = 205;
    localparam int DIV10_SHIFT  = 11;

    localparam logic [REM_W-1:0] HALF_TEN = 4'd5;
    localparam logic [REM_W-1:0] TEN      = 4'd10;

    typedef struct packed {
        logic                 valid;
        logic                 last;
        logic [VALUE_W-1:0]   value;
        logic [KEY_W-1:0]     key;
    } item_t;

    typedef struct packed {
        logic start;
        logic overflow;
    } scan_ctl_t;

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_WAIT,
        ST_READ,
        ST_CHECK
    } scan_state_t;

endpackage

// ----- rtl/core/stable_insertion_sort_by_ten_distance_unit.sv -----
`timescale 1ns / 1ps
// ============================================================================
// stable_insertion_sort_by_ten_distance_unit
// Stable sorter of signed values by distance to the nearest multiple of ten.
// ============================================================================
// Values are taken one per cycle while the block collects a set, and pass the
// key pipeline before they are written in arrival order into a single store
// of CAPACITY entries. The transaction marked tlast closes the set: input
// stalls, and the output sequencer reads the store once for each key from
// zero to five, reading each stored entry in a READ state and checking it in
// a CHECK state, emitting entries whose key matches that pass. The pace of the
// scan is bounded by the single read port of the store; results wait in an
// output register, so a stalled consumer only pauses the scan. Values beyond
// CAPACITY are dropped and flagged on every result of the run. The store
// needs no clearing after reset.
module stable_insertion_sort_by_ten_distance_unit #(
    parameter int CAPACITY = sisort_pkg::CAPACITY_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [31:0] value
    input  logic [sisort_pkg::VALUE_W-1:0]      s_axis_tdata,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [31:0] sorted_value, [34:32] distance_key, [39:35] zero
    output logic [sisort_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                                m_axis_tlast,
    // [0] overflowed
    output logic [0:0]                          m_axis_tuser
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);

    sisort_pkg::item_t               item;
    sisort_pkg::scan_ctl_t           ctl;

    logic [CNT_W-1:0]                count_reg, count_next;
    logic                            overflow_reg, overflow_next;
    logic                            full;
    logic                            wr_en;
    logic                            rd_en;
    logic [ADDR_W-1:0]               rd_addr;
    logic [sisort_pkg::ENTRY_W-1:0]  rd_data;
    logic                            done;
    logic                            accept;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign wr_en  = item.valid && !full;

    always_comb
    begin
        count_next    = count_reg;
        overflow_next = overflow_reg;
        if (done)
        begin
            count_next    = '0;
            overflow_next = 1'b0;
        end
        else if (item.valid)
        begin
            if (full)
            begin
                overflow_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
        end
    end

    assign ctl.start    = item.valid && item.last;
    assign ctl.overflow = overflow_reg;

    sisort_key u_key (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .in_last  (s_axis_tlast),
        .in_value (s_axis_tdata),
        .item     (item)
    );

    sisort_ram #(
        .WIDTH (sisort_pkg::ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data ({item.key, item.value}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sisort_scan #(
        .CAPACITY (CAPACITY)
    ) u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_tvalid     (s_axis_tvalid),
        .in_tlast      (s_axis_tlast),
        .in_tready     (s_axis_tready),
        .ctl           (ctl),
        .count         (count_reg),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .done          (done),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ----- rtl/core/sisort_ram.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sisort_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ============================================================================
module sisort_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/sisort_key.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sisort_key
// Three-stage pipeline that computes the distance of a value to the nearest
// multiple of ten.
// ============================================================================
module sisort_key (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_last,
    input  logic [sisort_pkg::VALUE_W-1:0]   in_value,
    output sisort_pkg::item_t                item
);

    // Stage one holds the magnitude, stage two the folded nibble sum.
    logic                            s1_valid_reg, s1_valid_next;
    logic                            s1_last_reg, s1_last_next;
    logic [sisort_pkg::VALUE_W-1:0]  s1_value_reg, s1_value_next;
    logic [sisort_pkg::VALUE_W-1:0]  s1_mag_reg, s1_mag_next;

    logic                            s2_valid_reg, s2_valid_next;
    logic                            s2_last_reg, s2_last_next;
    logic [sisort_pkg::VALUE_W-1:0]  s2_value_reg, s2_value_next;
    logic [sisort_pkg::SUM_W-1:0]    s2_sum_reg, s2_sum_next;

    sisort_pkg::item_t               item_reg, item_next;

    logic [sisort_pkg::SUM_W-1:0]    nib_sum;
    logic [sisort_pkg::PROD_W-1:0]   prod;
    logic [sisort_pkg::QUOT_W-1:0]   quot;
    logic [sisort_pkg::SUM_W-1:0]    rem_full;
    logic [sisort_pkg::REM_W-1:0]    rem;
    logic [sisort_pkg::REM_W-1:0]    folded;

    always_comb
    begin
        s1_valid_next = in_valid;
        s1_last_next  = in_last;
        s1_value_next = in_value;
        s1_mag_next   = in_value[sisort_pkg::VALUE_W-1] ? (~in_value + 1'b1) : in_value;
    end

    // Every power of sixteen above one leaves six modulo ten.
    always_comb
    begin
        nib_sum = '0;
        for (int i = 1; i < sisort_pkg::VALUE_W / 4; i++)
        begin
            nib_sum = nib_sum + sisort_pkg::SUM_W'(s1_mag_reg[i*4 +: 4]);
        end
        s2_valid_next = s1_valid_reg;
        s2_last_next  = s1_last_reg;
        s2_value_next = s1_value_reg;
        s2_sum_next   = (nib_sum << 2) + (nib_sum << 1)
                        + sisort_pkg::SUM_W'(s1_mag_reg[3:0]);
    end

    always_comb
    begin
        prod     = sisort_pkg::PROD_W'(s2_sum_reg)
                   * sisort_pkg::PROD_W'(sisort_pkg::DIV10_MUL);
        quot     = prod[sisort_pkg::DIV10_SHIFT +: sisort_pkg::QUOT_W];
        rem_full = s2_sum_reg - sisort_pkg::SUM_W'(quot) * sisort_pkg::SUM_W'(sisort_pkg::TEN);
        rem      = rem_full[sisort_pkg::REM_W-1:0];
        folded   = (rem <= sisort_pkg::HALF_TEN) ? rem : (sisort_pkg::TEN - rem);
        item_next.valid = s2_valid_reg;
        item_next.last  = s2_last_reg;
        item_next.value = s2_value_reg;
        item_next.key   = folded[sisort_pkg::KEY_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            item_reg       <= '0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            s2_valid_reg   <= s2_valid_next;
            item_reg       <= item_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_last_reg    <= s1_last_next;
        s1_value_reg   <= s1_value_next;
        s1_mag_reg     <= s1_mag_next;
        s2_last_reg    <= s2_last_next;
        s2_value_reg   <= s2_value_next;
        s2_sum_reg     <= s2_sum_next;
    end

    assign item = item_reg;

endmodule

// ----- rtl/core/sisort_scan.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sisort_scan
// Input gating and output sequencer: reads the store once per key value and
// emits matching entries in stored order.
// ============================================================================
module sisort_scan #(
    parameter int CAPACITY = sisort_pkg::CAPACITY_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_tvalid,
    input  logic                                in_tlast,
    output logic                                in_tready,
    input  sisort_pkg::scan_ctl_t               ctl,
    input  logic [$clog2(CAPACITY+1)-1:0]       count,
    output logic                                rd_en,
    output logic [$clog2(CAPACITY)-1:0]         rd_addr,
    input  logic [sisort_pkg::ENTRY_W-1:0]      rd_data,
    output logic                                done,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [sisort_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                                m_axis_tlast,
    output logic [0:0]                          m_axis_tuser
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);

    sisort_pkg::scan_state_t state_reg, state_next;

    logic [sisort_pkg::KEY_W-1:0]      pass_reg, pass_next;
    logic [CNT_W-1:0]                  idx_reg, idx_next;
    logic [CNT_W-1:0]                  emitted_reg, emitted_next;
    logic                              out_valid_reg, out_valid_next;
    logic [sisort_pkg::ENTRY_W-1:0]    out_data_reg, out_data_next;
    logic                              out_last_reg, out_last_next;
    logic                              out_ovf_reg, out_ovf_next;

    logic                              slot_free;
    logic                              end_of_pass;
    logic                              match;
    logic                              is_last;

    assign slot_free   = !out_valid_reg || m_axis_tready;
    assign end_of_pass = (idx_reg == count);
    assign match       = (rd_data[sisort_pkg::ENTRY_W-1 -: sisort_pkg::KEY_W] == pass_reg);
    assign is_last     = ((emitted_reg + 1'b1) == count);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sisort_pkg::ST_COLLECT:
            begin
                if (in_tvalid && in_tlast)
                begin
                    state_next = sisort_pkg::ST_WAIT;
                end
            end
            sisort_pkg::ST_WAIT:
            begin
                if (ctl.start)
                begin
                    state_next = sisort_pkg::ST_READ;
                end
            end
            sisort_pkg::ST_READ:
            begin
                if (!end_of_pass && slot_free)
                begin
                    state_next = sisort_pkg::ST_CHECK;
                end
            end
            sisort_pkg::ST_CHECK:
            begin
                if (match && is_last)
                begin
                    state_next = sisort_pkg::ST_COLLECT;
                end
                else
                begin
                    state_next = sisort_pkg::ST_READ;
                end
            end
            default:
            begin
                state_next = sisort_pkg::ST_COLLECT;
            end
        endcase
    end

    always_comb
    begin
        in_tready = 1'b0;
        rd_en     = 1'b0;
        done      = 1'b0;
        case (state_reg)
            sisort_pkg::ST_COLLECT:
            begin
                in_tready = 1'b1;
            end
            sisort_pkg::ST_READ:
            begin
                rd_en = !end_of_pass && slot_free;
            end
            sisort_pkg::ST_CHECK:
            begin
                done = match && is_last;
            end
            default:
            begin
                in_tready = 1'b0;
            end
        endcase
    end

    assign rd_addr = idx_reg[ADDR_W-1:0];

    always_comb
    begin
        pass_next      = pass_reg;
        idx_next       = idx_reg;
        emitted_next   = emitted_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        case (state_reg)
            sisort_pkg::ST_WAIT:
            begin
                pass_next    = '0;
                idx_next     = '0;
                emitted_next = '0;
            end
            sisort_pkg::ST_READ:
            begin
                if (end_of_pass)
                begin
                    pass_next = pass_reg + 1'b1;
                    idx_next  = '0;
                end
                else if (slot_free)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            sisort_pkg::ST_CHECK:
            begin
                if (match)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = rd_data;
                    out_last_next  = is_last;
                    out_ovf_next   = ctl.overflow;
                    emitted_next   = emitted_reg + 1'b1;
                end
            end
            default:
            begin
                pass_next = pass_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sisort_pkg::ST_COLLECT;
            pass_reg      <= '0;
            idx_reg       <= '0;
            emitted_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            idx_reg       <= idx_next;
            emitted_reg   <= emitted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = sisort_pkg::OUT_TDATA_W'(out_data_reg);
    assign m_axis_tlast    = out_last_reg;
    assign m_axis_tuser[0] = out_ovf_reg;

endmodule
